FILE: src/clist_pkg.sv
// Shared types and constants for the cursor linked list table.
// Holds command codes, status codes, controller states and the control struct.
package clist_pkg;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_HEAD   = 3'd2;
    localparam logic [2:0] CMD_ADV    = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD1   = 6'b000010,
        S_RD2   = 6'b000100,
        S_WR1   = 6'b001000,
        S_WR2   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic rd1;
        logic rd2;
        logic wr1;
        logic wr2;
        logic rdv;
        logic fin;
    } ctrl_t;

endpackage

FILE: src/clist_ctrl.sv
// Controller state machine for the cursor linked list table.
// Depends on clist_pkg; drives the datapath through a control struct.
module clist_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output clist_pkg::ctrl_t   ctrl
);
    import clist_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                ctrl.rd1   = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                ctrl.rd2   = 1'b1;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                ctrl.wr1   = 1'b1;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                ctrl.wr2   = 1'b1;
                ctrl.rdv   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                ctrl.fin   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_RD1))
        else $error("accept did not start sequence");
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fin |=> !busy)
        else $error("not idle after finish");
endmodule

FILE: src/clist_dp.sv
// Datapath for the cursor linked list table: link and value memories, pointers.
// Depends on clist_pkg; sequenced by clist_ctrl.
module clist_dp #(
    parameter int MAX_ENTRIES = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  clist_pkg::ctrl_t       ctrl,
    input  logic [2:0]             command,
    input  logic [31:0]            item_value,
    output logic                   done,
    output logic [31:0]            current_value,
    output logic                   current_valid,
    output logic [4:0]             element_count,
    output logic                   list_full,
    output logic [1:0]             status
);
    import clist_pkg::*;

    localparam int PW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam logic [PW-1:0] NUL = PW'(MAX_ENTRIES);

    logic [VALUE_BITS-1:0] val_mem [MAX_ENTRIES];
    logic [PW-1:0]         fwd_mem [MAX_ENTRIES];
    logic [PW-1:0]         bck_mem [MAX_ENTRIES];

    logic [PW-1:0] head_reg, tail_reg, cur_reg, cnt_reg;
    logic [2:0]    cmd_reg;
    logic [VALUE_BITS-1:0] in_reg;
    logic [1:0]    stat_reg;
    logic [PW-1:0] t_reg, p_reg, nx_reg, lp_reg, ln_reg;
    logic [VALUE_BITS-1:0] lv_reg, rv_reg;

    logic [PW-1:0] last;
    logic          cur_node;
    logic [PW-1:0] tsel;
    assign last     = cnt_reg - PW'(1);
    assign cur_node = cur_reg < cnt_reg;
    assign tsel     = cur_node ? cur_reg : tail_reg;

    // First phase reads the target (cursor or tail) and the last slot.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd1)
        begin
            t_reg  <= tsel;
            p_reg  <= bck_mem[tsel[AW-1:0]];
            nx_reg <= fwd_mem[tsel[AW-1:0]];
            lp_reg <= bck_mem[last[AW-1:0]];
            ln_reg <= fwd_mem[last[AW-1:0]];
            lv_reg <= val_mem[last[AW-1:0]];
        end
    end

    logic full_w, empty_w;
    assign full_w  = cnt_reg == NUL;
    assign empty_w = cnt_reg == '0;

    // Neighbor links of the moved entry after the unlink step.
    logic [PW-1:0] lp_e, ln_e;
    assign lp_e = (lp_reg == t_reg) ? p_reg : lp_reg;
    assign ln_e = (ln_reg == t_reg) ? nx_reg : ln_reg;

    // Remove: derived pointers after unlink, before compaction.
    logic [PW-1:0] h1, tl1, c1, c2, h2, tl2;
    logic          mv;
    assign mv = t_reg != last;
    always_comb
    begin
        h1  = (p_reg == NUL) ? nx_reg : head_reg;
        tl1 = (nx_reg == NUL) ? p_reg : tail_reg;
        c1  = (nx_reg != NUL) ? nx_reg : tl1;
        h2  = h1;
        tl2 = tl1;
        c2  = c1;
        if (mv)
        begin
            if (lp_e == NUL) h2 = t_reg;
            if (ln_e == NUL) tl2 = t_reg;
            if (c1 == last) c2 = t_reg;
        end
    end

    logic ins_w, rem_w;
    assign ins_w = (cmd_reg == CMD_INSERT) && !full_w;
    assign rem_w = (cmd_reg == CMD_REMOVE) && !empty_w;

    // The value read sees the cursor and the slot contents as they stand after the command.
    logic [PW-1:0] rv_addr;
    assign rv_addr = rem_w ? c2 : cur_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.rdv)
            rv_reg <= (rem_w && mv && (c2 == t_reg)) ? lv_reg : val_mem[rv_addr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr1 && ins_w)
        begin
            val_mem[cnt_reg[AW-1:0]] <= in_reg;
            if (empty_w)
            begin
                fwd_mem[cnt_reg[AW-1:0]] <= NUL;
                bck_mem[cnt_reg[AW-1:0]] <= NUL;
            end
            else if (!cur_node)
            begin
                fwd_mem[tail_reg[AW-1:0]] <= cnt_reg;
                bck_mem[cnt_reg[AW-1:0]] <= tail_reg;
                fwd_mem[cnt_reg[AW-1:0]] <= NUL;
            end
            else
            begin
                fwd_mem[cnt_reg[AW-1:0]] <= cur_reg;
                bck_mem[cnt_reg[AW-1:0]] <= p_reg;
                bck_mem[cur_reg[AW-1:0]] <= cnt_reg;
                if (p_reg != NUL) fwd_mem[p_reg[AW-1:0]] <= cnt_reg;
            end
        end
        else if (ctrl.wr1 && rem_w)
        begin
            if (p_reg != NUL) fwd_mem[p_reg[AW-1:0]] <= nx_reg;
            if (nx_reg != NUL) bck_mem[nx_reg[AW-1:0]] <= p_reg;
        end
        if (ctrl.wr2 && rem_w && mv)
        begin
            val_mem[t_reg[AW-1:0]] <= lv_reg;
            fwd_mem[t_reg[AW-1:0]] <= ln_e;
            bck_mem[t_reg[AW-1:0]] <= lp_e;
            if (lp_e != NUL) fwd_mem[lp_e[AW-1:0]] <= t_reg;
            if (ln_e != NUL) bck_mem[ln_e[AW-1:0]] <= t_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NUL;
            tail_reg <= NUL;
            cur_reg  <= NUL;
            cnt_reg  <= '0;
            cmd_reg  <= CMD_READ;
            stat_reg <= ST_DONE;
            in_reg   <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                cmd_reg <= command;
                in_reg  <= VALUE_BITS'(item_value);
            end
            if (ctrl.rd2)
            begin
                stat_reg <= ST_DONE;
                unique case (cmd_reg)
                    CMD_INSERT: if (full_w) stat_reg <= ST_FULL;
                    CMD_REMOVE: if (empty_w) stat_reg <= ST_EMPTY;
                    CMD_HEAD:   cur_reg <= (head_reg < cnt_reg) ? head_reg : NUL;
                    CMD_ADV:
                        if (cur_node)
                            cur_reg <= (nx_reg < cnt_reg) ? nx_reg : NUL;
                    default: ;
                endcase
            end
            if (ctrl.wr1 && ins_w)
            begin
                cnt_reg <= cnt_reg + PW'(1);
                if (empty_w)
                begin
                    head_reg <= cnt_reg;
                    tail_reg <= cnt_reg;
                end
                else if (!cur_node)
                    tail_reg <= cnt_reg;
                else if (p_reg == NUL)
                    head_reg <= cnt_reg;
            end
            if (ctrl.wr2 && rem_w)
            begin
                cnt_reg <= last;
                if (last == '0)
                begin
                    head_reg <= NUL;
                    tail_reg <= NUL;
                    cur_reg  <= NUL;
                end
                else
                begin
                    head_reg <= h2;
                    tail_reg <= tl2;
                    cur_reg  <= c2;
                end
            end
        end
    end

    logic valid_w;
    assign valid_w       = cur_reg < cnt_reg;
    assign done          = ctrl.fin;
    assign current_valid = ctrl.fin & valid_w;
    assign current_value = (ctrl.fin && valid_w) ? 32'(rv_reg) : 32'd0;
    assign element_count = 5'(cnt_reg);
    assign list_full     = full_w;
    assign status        = stat_reg;

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= NUL)
        else $error("count beyond capacity");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (head_reg == NUL && tail_reg == NUL && cur_reg == NUL))
        else $error("empty list with live pointers");
    a_ht: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (head_reg < cnt_reg && tail_reg < cnt_reg))
        else $error("head or tail outside used slots");
endmodule

FILE: src/cursor_linked_list_table_top.sv
// Top level of the cursor linked list table.
// Depends on clist_pkg, clist_ctrl and clist_dp.
//
//  channel  | handshake         | payload
//  command  | start / busy      | command, item_value
//  result   | done (strobe)     | current_value, current_valid, element_count,
//           |                   | list_full, status
//
// Every command passes through the accepting cycle, two read phases, two
// write phases and the result cycle, in that order. The result strobe is high
// in the result cycle and the next command can be accepted in the cycle after
// it. The phases are set by the link reads and link updates of a remove. Reset
// clears the pointers and count at once; no clearing pass. The receiver cannot
// stall the result.
module cursor_linked_list_table_top #(
    parameter int MAX_ENTRIES = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] item_value,
    output logic        done,
    output logic [31:0] current_value,
    output logic        current_valid,
    output logic [4:0]  element_count,
    output logic        list_full,
    output logic [1:0]  status
);
    import clist_pkg::*;

    ctrl_t ctrl;

    clist_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    clist_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .command       (command),
        .item_value    (item_value),
        .done          (done),
        .current_value (current_value),
        .current_valid (current_valid),
        .element_count (element_count),
        .list_full     (list_full),
        .status        (status)
    );
endmodule
